// ===== src/dbd_pkg.sv =====
// shared widths, constants and calendar tables for the date difference block
`timescale 1ns / 1ps
`default_nettype none
package dbd_pkg;

  // field widths
  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;
  localparam int SER_W   = 23;
  localparam int DOY_W   = 9;
  localparam int CORR_W  = 12;
  localparam int REM_W   = 7;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 24;

  // largest allowed year by default
  localparam int DEF_MAX_YEAR = 9999;

  // divide by 100 as multiply by reciprocal and shift, exact for 14-bit values
  localparam int RECIP_100   = 5243;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam int QUO_W       = PROD_W - RECIP_SHIFT;

  localparam int DAYS_YEAR = 365;
  localparam int CENTURY   = 100;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // month codes
  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  // pipeline advance enables shared by all stage registers
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } stg_en_t;

  // length of a month, february follows the leap flag
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic lp);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = lp ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the year before the first of a month, common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] m);
    logic [DOY_W-1:0] db;
    unique case (m)
      4'd1:    db = 9'd0;
      4'd2:    db = 9'd31;
      4'd3:    db = 9'd59;
      4'd4:    db = 9'd90;
      4'd5:    db = 9'd120;
      4'd6:    db = 9'd151;
      4'd7:    db = 9'd181;
      4'd8:    db = 9'd212;
      4'd9:    db = 9'd243;
      4'd10:   db = 9'd273;
      4'd11:   db = 9'd304;
      4'd12:   db = 9'd334;
      default: db = 9'd0;
    endcase
    return db;
  endfunction

endpackage
`default_nettype wire

// ===== src/dbd_date.sv =====
// three-stage check and day serial number of one date
`timescale 1ns / 1ps
`default_nettype none
module dbd_date #(
  parameter int MAX_YEAR = dbd_pkg::DEF_MAX_YEAR
) (
  input  wire logic                         clk,
  input  wire dbd_pkg::stg_en_t             en,
  input  wire logic [dbd_pkg::DAY_W-1:0]    day,
  input  wire logic [dbd_pkg::MON_W-1:0]    month,
  input  wire logic [dbd_pkg::YEAR_W-1:0]   year,
  output logic      [dbd_pkg::SER_W-1:0]    serial,
  output logic                              ok
);

  localparam int YCMP_W = 16;

  // stage 1: quotients by 100 of the year and of the year before
  logic [dbd_pkg::PROD_W-1:0] prod_y;
  logic [dbd_pkg::PROD_W-1:0] prod_p;
  logic [dbd_pkg::YEAR_W-1:0] p_in;

  assign p_in   = year - dbd_pkg::YEAR_W'(1);
  assign prod_y = dbd_pkg::PROD_W'(year) * dbd_pkg::PROD_W'(dbd_pkg::RECIP_100);
  assign prod_p = dbd_pkg::PROD_W'(p_in) * dbd_pkg::PROD_W'(dbd_pkg::RECIP_100);

  logic [dbd_pkg::DAY_W-1:0]  d1;
  logic [dbd_pkg::MON_W-1:0]  m1;
  logic [dbd_pkg::YEAR_W-1:0] y1;
  logic [dbd_pkg::YEAR_W-1:0] p1;
  logic [dbd_pkg::QUO_W-1:0]  qy1;
  logic [dbd_pkg::QUO_W-1:0]  qp1;

  always_ff @(posedge clk) begin
    if (en.en1) begin
      d1  <= day;
      m1  <= month;
      y1  <= year;
      p1  <= p_in;
      qy1 <= prod_y[dbd_pkg::PROD_W-1:dbd_pkg::RECIP_SHIFT];
      qp1 <= prod_p[dbd_pkg::PROD_W-1:dbd_pkg::RECIP_SHIFT];
    end
  end

  // stage 2: leap year, date check, year days and leap corrections
  logic [dbd_pkg::YEAR_W-1:0] hund;
  logic [dbd_pkg::REM_W-1:0]  rem;
  logic                       lp;
  logic [dbd_pkg::DAY_W-1:0]  len;
  logic                       ok_c;
  logic [dbd_pkg::SER_W-1:0]  p365_c;
  logic [dbd_pkg::CORR_W-1:0] corr_c;
  logic [dbd_pkg::DOY_W-1:0]  doy_c;
  logic [dbd_pkg::YEAR_W-1:0] p_q4;

  assign hund = dbd_pkg::YEAR_W'(qy1) * dbd_pkg::YEAR_W'(dbd_pkg::CENTURY);
  assign rem  = dbd_pkg::REM_W'(y1 - hund);
  assign lp   = ((y1[1:0] == 2'd0) && (rem != '0)) || ((rem == '0) && (qy1[1:0] == 2'd0));
  assign len  = dbd_pkg::month_len(m1, lp);
  assign p_q4 = p1 >> 2;

  always_comb begin
    ok_c = (m1 >= dbd_pkg::MON_JAN) && (m1 <= dbd_pkg::MON_DEC) &&
           (y1 != '0) && (YCMP_W'(y1) <= YCMP_W'(MAX_YEAR)) &&
           (d1 != '0) && (d1 <= len);
    p365_c = dbd_pkg::SER_W'(p1) * dbd_pkg::SER_W'(dbd_pkg::DAYS_YEAR);
    corr_c = dbd_pkg::CORR_W'(p_q4) - dbd_pkg::CORR_W'(qp1) + dbd_pkg::CORR_W'(qp1 >> 2);
    doy_c  = dbd_pkg::days_before(m1) + dbd_pkg::DOY_W'(d1) +
             dbd_pkg::DOY_W'((m1 > dbd_pkg::MON_FEB) && lp);
  end

  logic                       ok2;
  logic [dbd_pkg::SER_W-1:0]  p365_2;
  logic [dbd_pkg::CORR_W-1:0] corr2;
  logic [dbd_pkg::DOY_W-1:0]  doy2;

  always_ff @(posedge clk) begin
    if (en.en2) begin
      ok2    <= ok_c;
      p365_2 <= p365_c;
      corr2  <= corr_c;
      doy2   <= doy_c;
    end
  end

  // stage 3: final serial sum
  always_ff @(posedge clk) begin
    if (en.en3) begin
      ok     <= ok2;
      serial <= p365_2 + dbd_pkg::SER_W'(corr2) + dbd_pkg::SER_W'(doy2);
    end
  end

endmodule
`default_nettype wire

// ===== src/dbd_count.sv =====
// difference of serials, end-day flag, saturation and the output register
`timescale 1ns / 1ps
`default_nettype none
module dbd_count (
  input  wire logic                          clk,
  input  wire dbd_pkg::stg_en_t              en,
  input  wire logic [dbd_pkg::SER_W-1:0]     start_serial,
  input  wire logic [dbd_pkg::SER_W-1:0]     end_serial,
  input  wire logic                          both_ok,
  input  wire logic                          include_end_day,
  output logic      [dbd_pkg::COUNT_W-1:0]   day_count,
  output logic                               invalid_date
);

  localparam int SUM_W = dbd_pkg::SER_W + 1;

  logic [SUM_W-1:0] diff;
  logic [SUM_W-1:0] total;
  logic [dbd_pkg::COUNT_W-1:0] count_c;

  // zero when start is not before end, then flag and clamp
  always_comb begin
    diff  = (start_serial < end_serial) ? SUM_W'(end_serial - start_serial) : '0;
    total = diff + SUM_W'(include_end_day);
    if (!both_ok) begin
      count_c = '0;
    end else if (total > SUM_W'(dbd_pkg::COUNT_MAX)) begin
      count_c = dbd_pkg::COUNT_MAX;
    end else begin
      count_c = dbd_pkg::COUNT_W'(total);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en.en4) begin
      day_count    <= count_c;
      invalid_date <= !both_ok;
    end
  end

endmodule
`default_nettype wire

// ===== src/days_between_dates.sv =====
// top level: stream ports, pipeline valid control, two date units and the count stage
// path: an accepted input word passes the stage 1, 2 and 3 registers of the date units, then the count output register
// throughput: one word per cycle; each stage stalls only when the one after it is full
// the serial multiply and adds of each date set the stage split
// reset: rst clears the stage valid bits, so the pipeline starts empty; data is not cleared
`timescale 1ns / 1ps
`default_nettype none
module days_between_dates #(
  parameter int MAX_YEAR = dbd_pkg::DEF_MAX_YEAR
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_day, start_month, start_year, end_day, end_month, end_year, include_end_day
  input  wire logic [dbd_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // day_count, invalid_date
  output logic      [dbd_pkg::OUT_W-1:0]  m_axis_tdata
);

  // input word fields
  logic [dbd_pkg::DAY_W-1:0]  start_day;
  logic [dbd_pkg::MON_W-1:0]  start_month;
  logic [dbd_pkg::YEAR_W-1:0] start_year;
  logic [dbd_pkg::DAY_W-1:0]  end_day;
  logic [dbd_pkg::MON_W-1:0]  end_month;
  logic [dbd_pkg::YEAR_W-1:0] end_year;
  logic                       include_end_day;

  assign start_day       = s_axis_tdata[4:0];
  assign start_month     = s_axis_tdata[8:5];
  assign start_year      = s_axis_tdata[22:9];
  assign end_day         = s_axis_tdata[27:23];
  assign end_month       = s_axis_tdata[31:28];
  assign end_year        = s_axis_tdata[45:32];
  assign include_end_day = s_axis_tdata[46];

  // stage valid bits and advance enables
  logic v1, v2, v3, v4;
  dbd_pkg::stg_en_t en;

  always_comb begin
    en.en4 = !v4 || m_axis_tready;
    en.en3 = !v3 || en.en4;
    en.en2 = !v2 || en.en3;
    en.en1 = !v1 || en.en2;
  end

  assign s_axis_tready = en.en1;
  assign m_axis_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.en1) v1 <= s_axis_tvalid;
      if (en.en2) v2 <= v1;
      if (en.en3) v3 <= v2;
      if (en.en4) v4 <= v3;
    end
  end

  // end-day flag rides alongside the date units
  logic inc1, inc2, inc3;

  always_ff @(posedge clk) begin
    if (en.en1) inc1 <= include_end_day;
    if (en.en2) inc2 <= inc1;
    if (en.en3) inc3 <= inc2;
  end

  // date units
  logic [dbd_pkg::SER_W-1:0] start_serial;
  logic [dbd_pkg::SER_W-1:0] end_serial;
  logic                      start_ok;
  logic                      end_ok;

  dbd_date #(.MAX_YEAR(MAX_YEAR)) u_start (
    .clk    (clk),
    .en     (en),
    .day    (start_day),
    .month  (start_month),
    .year   (start_year),
    .serial (start_serial),
    .ok     (start_ok)
  );

  dbd_date #(.MAX_YEAR(MAX_YEAR)) u_end (
    .clk    (clk),
    .en     (en),
    .day    (end_day),
    .month  (end_month),
    .year   (end_year),
    .serial (end_serial),
    .ok     (end_ok)
  );

  // count and output register
  logic [dbd_pkg::COUNT_W-1:0] day_count;
  logic                        invalid_date;

  dbd_count u_count (
    .clk             (clk),
    .en              (en),
    .start_serial    (start_serial),
    .end_serial      (end_serial),
    .both_ok         (start_ok && end_ok),
    .include_end_day (inc3),
    .day_count       (day_count),
    .invalid_date    (invalid_date)
  );

  assign m_axis_tdata = {1'b0, invalid_date, day_count};

  // an invalid word always carries a zero count
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[22] |-> m_axis_tdata[21:0] == '0)
    else $error("invalid word with nonzero count");

  // an empty output stage means the whole pipeline can advance
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // a word in stage three moves to the output when the output can load
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    v3 && en.en4 |=> m_axis_tvalid)
    else $error("word lost between stage three and output");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !v1 && !v2 && !v3)
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// ===== dv/tb_days_between_dates.sv =====
// testbench for the date difference block: directed and random date pairs against a scoreboard
`timescale 1ns / 1ps
module tb_days_between_dates;
  import dbd_pkg::*;

  localparam int TOP_YEAR    = DEF_MAX_YEAR;
  localparam int RAND_WORDS  = 750;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_START  = 300;
  localparam int HOLD_LEN    = 150;
  localparam int RX_CALM_LO  = 500;
  localparam int RX_CALM_HI  = 700;
  localparam int TX_CALM_LO  = 400;
  localparam int TX_CALM_HI  = 560;
  localparam int TAIL_CYCLES = 8;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  // expected result of one date pair
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               invalid;
  } span_t;

  // predicts the day span of each accepted date pair and checks results in order
  class day_span_board;
    span_t       expected_spans[$];
    int unsigned mismatches = 0;
    int unsigned cum_days[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int unsigned mon_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    function bit leap_year(int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function int unsigned days_in_month(int unsigned m, int unsigned y);
      if (m < 1 || m > 12) return 0;
      if (m == 2 && leap_year(y)) return 29;
      return mon_days[m-1];
    endfunction

    function bit date_valid(int unsigned d, int unsigned m, int unsigned y);
      if (m < 1 || m > 12) return 1'b0;
      if (y < 1 || y > TOP_YEAR) return 1'b0;
      return d >= 1 && d <= days_in_month(m, y);
    endfunction

    // day number counted from 1 january of year 1
    function int unsigned day_serial(int unsigned d, int unsigned m, int unsigned y);
      int unsigned p;
      int unsigned s;
      p = y - 1;
      s = 365 * p + p / 4 - p / 100 + p / 400 + cum_days[m-1] + d;
      if (m > 2 && leap_year(y)) s++;
      return s;
    endfunction

    function span_t predict_span(logic [IN_W-1:0] w);
      int unsigned sd, sm, sy, ed, em, ey, inc, a, b, cnt;
      span_t       sp;
      sd  = w[4:0];
      sm  = w[8:5];
      sy  = w[22:9];
      ed  = w[27:23];
      em  = w[31:28];
      ey  = w[45:32];
      inc = w[46];
      sp  = '0;
      if (!date_valid(sd, sm, sy) || !date_valid(ed, em, ey)) begin
        sp.invalid = 1'b1;
      end else begin
        a   = day_serial(sd, sm, sy);
        b   = day_serial(ed, em, ey);
        cnt = (a < b) ? b - a : 0;
        cnt += inc;
        if (cnt > COUNT_MAX) cnt = COUNT_MAX;
        sp.count = cnt[COUNT_W-1:0];
      end
      return sp;
    endfunction

    function void note_dates(logic [IN_W-1:0] w);
      expected_spans.push_back(predict_span(w));
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_span(logic [OUT_W-1:0] w);
      span_t exp_sp;
      if (expected_spans.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", w));
        return;
      end
      exp_sp = expected_spans.pop_front();
      if (w[COUNT_W-1:0] !== exp_sp.count)
        report_mismatch($sformatf("day_count %0d, expected %0d", w[COUNT_W-1:0], exp_sp.count));
      if (w[COUNT_W] !== exp_sp.invalid)
        report_mismatch($sformatf("invalid_date %b, expected %b", w[COUNT_W], exp_sp.invalid));
    endtask

    function int unsigned pending();
      return expected_spans.size();
    endfunction
  endclass

  day_span_board board = new();

  bit calm_tx = 1'b0;
  int unsigned idle_cycles = 0;

  days_between_dates DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // pack one date pair, start day in the lowest bits
  function automatic logic [IN_W-1:0] pack_dates(int unsigned sd, int unsigned sm,
                                                 int unsigned sy, int unsigned ed,
                                                 int unsigned em, int unsigned ey,
                                                 int unsigned inc);
    logic [IN_W-1:0] w;
    w = '0;
    w[4:0]   = sd[4:0];
    w[8:5]   = sm[3:0];
    w[22:9]  = sy[13:0];
    w[27:23] = ed[4:0];
    w[31:28] = em[3:0];
    w[45:32] = ey[13:0];
    w[46]    = inc[0];
    return w;
  endfunction

  // random well-formed date, weighted toward century and range edges
  task automatic pick_date(output int unsigned d, output int unsigned m, output int unsigned y);
    int unsigned edge_years[10] = '{1, 4, 100, 400, 1600, 1900, 2000, 2100, 9996, 9999};
    if ($urandom_range(9) == 0) y = edge_years[$urandom_range(9)];
    else y = $urandom_range(TOP_YEAR, 1);
    m = $urandom_range(12, 1);
    if ($urandom_range(3) == 0) d = board.days_in_month(m, y);
    else d = $urandom_range(board.days_in_month(m, y), 1);
  endtask

  // offer one word, idling now and then, and wait until it is taken
  task automatic send_word(input logic [IN_W-1:0] w);
    while (!calm_tx && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_directed();
    send_word(pack_dates(1, 1, 1, 31, 12, TOP_YEAR, 1));
    send_word(pack_dates(1, 1, 1, 31, 12, TOP_YEAR, 0));
    send_word(pack_dates(31, 12, TOP_YEAR, 1, 1, 1, 0));
    send_word(pack_dates(31, 12, TOP_YEAR, 1, 1, 1, 1));
    send_word(pack_dates(15, 6, 2024, 15, 6, 2024, 0));
    send_word(pack_dates(15, 6, 2024, 15, 6, 2024, 1));
    send_word(pack_dates(28, 2, 2000, 1, 3, 2000, 0));
    send_word(pack_dates(28, 2, 1900, 1, 3, 1900, 0));
    send_word(pack_dates(29, 2, 1900, 1, 3, 1900, 1));
    send_word(pack_dates(29, 2, 2004, 1, 3, 2004, 1));
    send_word(pack_dates(1, 1, 2001, 29, 2, 2001, 0));
    send_word(pack_dates(31, 12, 1999, 1, 1, 2000, 0));
    send_word(pack_dates(1, 0, 2000, 1, 1, 2001, 1));
    send_word(pack_dates(1, 1, 2000, 1, 13, 2001, 0));
    send_word(pack_dates(1, 1, 2000, 1, 15, 2001, 1));
    send_word(pack_dates(0, 1, 2000, 1, 1, 2001, 0));
    send_word(pack_dates(1, 1, 2000, 31, 4, 2001, 0));
    send_word(pack_dates(30, 4, 2000, 31, 12, 2001, 1));
    send_word(pack_dates(1, 1, 0, 1, 1, 2001, 0));
    send_word(pack_dates(1, 1, 2000, 1, 1, TOP_YEAR + 1, 1));
    send_word(pack_dates(31, 15, 16383, 31, 15, 16383, 1));
  endtask

  task automatic send_random();
    int unsigned sd, sm, sy, ed, em, ey, inc;
    for (int i = 0; i < RAND_WORDS; i++) begin
      calm_tx = (i >= TX_CALM_LO && i < TX_CALM_HI);
      inc = $urandom_range(1);
      pick_date(sd, sm, sy);
      pick_date(ed, em, ey);
      // close pairs give short spans and exercise ordering
      if ($urandom_range(9) < 4) begin
        ey = (sy < TOP_YEAR && $urandom_range(1)) ? sy + 1 : sy;
        ed = $urandom_range(board.days_in_month(em, ey), 1);
      end
      case ($urandom_range(19))
        0: begin
          sd = $urandom_range(31); sm = $urandom_range(15); sy = $urandom_range(16383);
          ed = $urandom_range(31); em = $urandom_range(15); ey = $urandom_range(16383);
        end
        1: sd = $urandom_range(1) ? 0 : $urandom_range(31, board.days_in_month(sm, sy) + 1);
        2: em = $urandom_range(1) ? 0 : $urandom_range(15, 13);
        3: sy = $urandom_range(1) ? 0 : $urandom_range(16383, TOP_YEAR + 1);
        default: ;
      endcase
      send_word(pack_dates(sd, sm, sy, ed, em, ey, inc));
    end
    calm_tx = 1'b0;
  endtask

  // main sequence
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_directed();
    send_random();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off and a calm stretch
  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      if (!rst) rx_cycle++;
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
        m_axis_tready <= 1'b0;
      end else if (rx_cycle >= RX_CALM_LO && rx_cycle < RX_CALM_HI) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 10);
      end
    end
  end

  // monitor both sides and watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) board.check_span(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) board.note_dates(s_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
